FILE: rtl/mmacn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mmacn_pkg - shared types and constants of the min/max auto-cal normalizer
// Holds the sequencer state type, op codes and configuration register indexes.
// -----------------------------------------------------------------------------
package mmacn_pkg;

    localparam int OP_BITS      = 2;
    localparam int CFG_IDX_BITS = 2;

    // Request op codes
    localparam logic [OP_BITS-1:0] OP_UPDATE  = 2'd0;
    localparam logic [OP_BITS-1:0] OP_MAP     = 2'd1;
    localparam logic [OP_BITS-1:0] OP_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_MIN = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INITIAL_MAX = 2'd1;

    // Span below which the saved pair takes over
    localparam int SPAN_THRESHOLD = 10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_SELECT,
        S_CLASS,
        S_DIV,
        S_FINISH
    } t_state;

endpackage : mmacn_pkg
`default_nettype wire

FILE: rtl/mmacn_div.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// mmacn_div - radix-2 restoring divider, one quotient bit per cycle
// Computes floor(num * 2^Q_BITS / den) for num < den.
// -----------------------------------------------------------------------------
module mmacn_div #(
    parameter int W_BITS = 17,
    parameter int Q_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [W_BITS-1:0] i_num,
    input  wire logic [W_BITS-1:0] i_den,
    output logic                   o_done,
    output logic [Q_BITS-1:0]      o_quot
);

    localparam int CNT_BITS = $clog2(Q_BITS + 1);

    logic [W_BITS:0]   r_rem;
    logic [W_BITS-1:0] r_den;
    logic [Q_BITS-1:0] r_quot;
    logic [CNT_BITS-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [W_BITS:0]   n_shift;
    logic              n_bit;

    always_comb begin
        n_shift = {r_rem[W_BITS-1:0], 1'b0};
        n_bit   = (n_shift >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(Q_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift one quotient bit in per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_bit ? (n_shift - {1'b0, r_den}) : n_shift;
            r_quot <= {r_quot[Q_BITS-2:0], n_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule : mmacn_div
`default_nettype wire

FILE: rtl/minmax_autocal_normalizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// minmax_autocal_normalizer_top - min/max auto-calibrating sensor normalizer
// Tracks sample extremes, keeps a fallback pair, maps samples to a fraction.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one request: an op and a
//   signed sample. Op update widens the current min/max (or seeds it on the
//   first sample after a restart), op restart saves the current pair as the
//   fallback pair, op map places the sample between the effective bounds.
//   Output channel (o_out_valid / i_out_ready) returns exactly one result per
//   request: fraction (2^FRAC_BITS = 1.0), effective bounds and fell_back.
//   Sequencing: a request passes through the apply, select and classify
//   steps; a map request that needs a division then runs the radix-2
//   divider, one quotient bit per cycle, before the finish step loads the
//   result. One request is in work at a time (o_in_ready is high while
//   idle), so a new request is taken only after the last one is finished.
//   A finished result sits in the output register; the next request is taken
//   while it waits. If the receiver still stalls when the next result is
//   done, the sequencer holds in its final step until the register frees.
//   Reset (synchronous, active low) loads initial_min = 0 and
//   initial_max = 1000 into both pairs and arms the first-sample flag.
//   Configuration writes (i_cfg_wr_en) load a bound into both pairs and
//   re-arm the first-sample flag; write them only while the block is idle.
// -----------------------------------------------------------------------------
module minmax_autocal_normalizer_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [mmacn_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  wire logic [SAMPLE_BITS-1:0]              i_cfg_data,
    // Request channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [mmacn_pkg::OP_BITS-1:0]       i_op,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_sample,
    // Result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [FRAC_BITS:0]                       o_fraction,
    output logic signed [SAMPLE_BITS-1:0]            o_used_min,
    output logic signed [SAMPLE_BITS-1:0]            o_used_max,
    output logic                                     o_fell_back
);

    import mmacn_pkg::*;

    localparam int W_BITS = SAMPLE_BITS + 1;

    t_state r_state, n_state;

    // Calibration state
    logic signed [SAMPLE_BITS-1:0] r_cur_lo, r_cur_hi, r_saved_lo, r_saved_hi;
    logic                          r_awaiting_first;

    // Request being worked on
    logic [OP_BITS-1:0]            r_op;
    logic signed [SAMPLE_BITS-1:0] r_sample;

    // Effective pair and classification
    logic signed [SAMPLE_BITS-1:0] r_lo, r_hi;
    logic                          r_fb;
    logic                          r_le_lo, r_ge_hi;
    logic [W_BITS-1:0]             div_num, div_den;

    // Output register
    logic                          r_out_valid;
    logic [FRAC_BITS:0]            r_fraction;
    logic signed [SAMPLE_BITS-1:0] r_used_min, r_used_max;
    logic                          r_fell_back;

    logic                          accept;
    logic                          div_start;
    logic                          div_done;
    logic [FRAC_BITS-1:0]          div_quot;
    logic                          out_load;
    logic                          needs_div;

    logic signed [W_BITS-1:0]      span_diff;
    logic [W_BITS-1:0]             span_abs;
    logic                          span_small;
    logic                          le_lo, ge_hi;

    assign accept = i_in_valid && (r_state == S_IDLE);

    // Span of the current pair decides the fallback
    always_comb begin
        span_diff  = W_BITS'(r_cur_lo) - W_BITS'(r_cur_hi);
        span_abs   = span_diff[W_BITS-1] ? W_BITS'(-span_diff) : W_BITS'(span_diff);
        span_small = (span_abs < W_BITS'(SPAN_THRESHOLD));
        le_lo      = (r_sample <= r_lo);
        ge_hi      = (r_sample >= r_hi);
        needs_div  = (r_op == OP_MAP) && !le_lo && !ge_hi;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_APPLY;
            end
            S_APPLY: begin
                n_state = S_SELECT;
            end
            S_SELECT: begin
                n_state = S_CLASS;
            end
            S_CLASS: begin
                if (needs_div) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_DIV: begin
                if (div_done) n_state = S_FINISH;
            end
            S_FINISH: begin
                // Hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Calibration state: config writes, update and restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_lo         <= '0;
            r_saved_lo       <= '0;
            r_cur_hi         <= SAMPLE_BITS'(1000);
            r_saved_hi       <= SAMPLE_BITS'(1000);
            r_awaiting_first <= 1'b1;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_idx == CFG_INITIAL_MIN) begin
                r_cur_lo         <= i_cfg_data;
                r_saved_lo       <= i_cfg_data;
                r_awaiting_first <= 1'b1;
            end else if (i_cfg_idx == CFG_INITIAL_MAX) begin
                r_cur_hi         <= i_cfg_data;
                r_saved_hi       <= i_cfg_data;
                r_awaiting_first <= 1'b1;
            end
        end else if (r_state == S_APPLY) begin
            if (r_op == OP_UPDATE) begin
                if (r_awaiting_first) begin
                    r_awaiting_first <= 1'b0;
                    r_cur_lo         <= r_sample;
                    r_cur_hi         <= r_sample;
                end else begin
                    if (r_sample < r_cur_lo) r_cur_lo <= r_sample;
                    if (r_sample > r_cur_hi) r_cur_hi <= r_sample;
                end
            end else if (r_op == OP_RESTART) begin
                r_saved_lo       <= r_cur_lo;
                r_saved_hi       <= r_cur_hi;
                r_awaiting_first <= 1'b1;
            end
        end
    end

    // Request capture, pair selection and divider operands
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= i_op;
            r_sample <= i_sample;
        end
        if (r_state == S_SELECT) begin
            r_fb <= span_small;
            r_lo <= span_small ? r_saved_lo : r_cur_lo;
            r_hi <= span_small ? r_saved_hi : r_cur_hi;
        end
        if (r_state == S_CLASS) begin
            r_le_lo <= le_lo;
            r_ge_hi <= ge_hi;
        end
    end

    always_comb begin
        div_num = W_BITS'(r_sample) - W_BITS'(r_lo);
        div_den = W_BITS'(r_hi) - W_BITS'(r_lo);
    end

    mmacn_div #(
        .W_BITS (W_BITS),
        .Q_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Output register: advance on load, drop valid when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_used_min  <= r_lo;
            r_used_max  <= r_hi;
            r_fell_back <= r_fb;
            if (r_op != OP_MAP || r_le_lo) begin
                r_fraction <= '0;
            end else if (r_ge_hi) begin
                r_fraction <= {1'b1, {FRAC_BITS{1'b0}}};
            end else begin
                r_fraction <= {1'b0, div_quot};
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_fraction  = r_fraction;
    assign o_used_min  = r_used_min;
    assign o_used_max  = r_used_max;
    assign o_fell_back = r_fell_back;

endmodule : minmax_autocal_normalizer_top
`default_nettype wire
